>>> hw/rtl/relay_watchdog_power_cycler_core_macros.svh
// Assertion macros used by the checker file.
`ifndef RELAY_WATCHDOG_POWER_CYCLER_CORE_MACROS_SVH
`define RELAY_WATCHDOG_POWER_CYCLER_CORE_MACROS_SVH

// Concurrent assertion on the rising clock, quiet while reset is high.
`define RWPC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rwpc assertion failed");

// Concurrent assertion that is also checked while reset is high.
`define RWPC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("rwpc assertion failed");

`endif

>>> hw/rtl/rwpc_pkg.sv
// Package: constants and codes of the relay watchdog power cycler.
`timescale 1ns / 1ps
`default_nettype none
package rwpc_pkg;

  localparam int COUNT_BITS = 16;

  localparam int RELOAD_W = 16;
  localparam int LONG_W   = 8;
  localparam int HOLD_W   = 8;

  localparam logic [RELOAD_W-1:0] RELOAD_RESET = 16'd600;
  localparam logic [LONG_W-1:0]   LONG_RESET   = 8'd50;
  localparam logic                MODE_RESET   = 1'b1;
  localparam logic [HOLD_W-1:0]   HOLD_MAX     = 8'hFF;

  // event kinds
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_SERIAL = 2'd1;
  localparam logic [1:0] REQ_BUTTON = 2'd2;

  localparam logic [7:0] CMD_KEEPALIVE = 8'd1;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_RELOAD = 2'd0;
  localparam logic [1:0] REG_LONG   = 2'd1;
  localparam logic [1:0] REG_SAVED  = 2'd2;

  localparam int ADDR_W   = 4;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

endpackage
`default_nettype wire

>>> hw/rtl/relay_watchdog_power_cycler_core.sv
// Top level: relay controller with software watchdog and button handling.
// The result item is registered and becomes valid in the cycle after the input item is accepted.
// Throughput: one item per cycle unless the output stalls; the single result register lets a new item
// in while the previous result is being taken.
// Reset (rst, synchronous): registers to defaults, mode plain, relay high,
// LED low, countdown zero, output empty.
`timescale 1ns / 1ps
`default_nettype none
module relay_watchdog_power_cycler_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // tdata: [7:0] command, [8] button_pressed, [15:9] zero
  input  wire logic [rwpc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: [1:0] req_type
  input  wire logic [rwpc_pkg::IN_USER_W-1:0]    s_axis_tuser,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: [0] relay_on, [1] led_on, [2] mode_now, [3] reboot_pulse,
  //        [4] save_mode, [5] ack_valid, [7:6] zero
  output logic [rwpc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rwpc_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import rwpc_pkg::*;

  logic [RELOAD_W-1:0]   timeout_reload;
  logic [LONG_W-1:0]     long_press_samples;
  logic                  saved_mode;

  logic                  mode, mode_next;
  logic [COUNT_BITS-1:0] countdown, countdown_next;
  logic                  relay_level, relay_level_next;
  logic                  led_level, led_level_next;
  logic [HOLD_W-1:0]     hold_count, hold_count_next;
  logic                  holding, holding_next;
  logic                  pulse, save, ack;

  logic                  in_fire, cfg_wr;
  logic [1:0]            req;
  logic [7:0]            cmd;
  logic                  pressed;
  logic [HOLD_W-1:0]     hold_inc;
  logic [COUNT_BITS-1:0] reload;

  assign pready        = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_wr        = psel && penable && pwrite && pready;

  assign req     = s_axis_tuser;
  assign cmd     = s_axis_tdata[7:0];
  assign pressed = s_axis_tdata[8];
  assign reload  = COUNT_BITS'(timeout_reload);
  assign hold_inc = (hold_count < HOLD_MAX) ? hold_count + 1'b1 : hold_count;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_RELOAD: prdata = 32'(timeout_reload);
      REG_LONG:   prdata = 32'(long_press_samples);
      REG_SAVED:  prdata = 32'(saved_mode);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_reload     <= RELOAD_RESET;
      long_press_samples <= LONG_RESET;
      saved_mode         <= MODE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RELOAD: timeout_reload     <= pwdata[RELOAD_W-1:0];
        REG_LONG:   long_press_samples <= pwdata[LONG_W-1:0];
        REG_SAVED:  saved_mode         <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_next        = mode;
    countdown_next   = countdown;
    relay_level_next = relay_level;
    led_level_next   = led_level;
    hold_count_next  = hold_count;
    holding_next     = holding;
    pulse            = 1'b0;
    save             = 1'b0;
    ack              = 1'b0;
    case (req)
      REQ_TICK: begin
        if (!holding) begin
          if (mode) begin
            led_level_next = !relay_level;
          end else if (countdown != '0) begin
            countdown_next = countdown - 1'b1;
            led_level_next = !led_level;
          end else begin
            pulse            = 1'b1;
            relay_level_next = 1'b0;
            countdown_next   = reload;
          end
        end
      end
      REQ_SERIAL: begin
        if (cmd == CMD_KEEPALIVE) begin
          countdown_next = reload;
          ack            = 1'b1;
        end
      end
      REQ_BUTTON: begin
        if (pressed) begin
          if (!holding) begin
            holding_next    = 1'b1;
            hold_count_next = '0;
          end else begin
            hold_count_next = hold_inc;
            if (hold_inc > long_press_samples) led_level_next = !led_level;
          end
        end else if (holding) begin
          if (hold_count > long_press_samples) begin
            mode_next = !mode;
            save      = 1'b1;
          end else begin
            relay_level_next = !relay_level;
          end
          holding_next    = 1'b0;
          hold_count_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_RESET;
      countdown   <= '0;
      relay_level <= MODE_RESET;
      led_level   <= !MODE_RESET;
      hold_count  <= '0;
      holding     <= 1'b0;
    end else if (in_fire) begin
      mode        <= mode_next;
      countdown   <= countdown_next;
      relay_level <= relay_level_next;
      led_level   <= led_level_next;
      hold_count  <= hold_count_next;
      holding     <= holding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= {2'b00, ack, save, pulse, mode_next, led_level_next, relay_level_next};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/rwpc_checker.sv
// Checker: port-level properties of the relay watchdog power cycler.
`timescale 1ns / 1ps
`default_nettype none
`include "relay_watchdog_power_cycler_core_macros.svh"
module rwpc_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_axis_tready,
  input wire logic [rwpc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire logic                              m_axis_tvalid,
  input wire logic                              pready
);
  import rwpc_pkg::*;

  // a reboot pulse only happens in watchdog mode and leaves the relay low
  `RWPC_ASSERT(a_pulse_relay_low, clk, rst, m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[0] && !m_axis_tdata[2])

  // pulse, save and ack come from different event kinds
  `RWPC_ASSERT(a_flags_exclusive, clk, rst, m_axis_tvalid |-> $countones(m_axis_tdata[5:3]) <= 1)

  // an empty result register never holds off the input
  `RWPC_ASSERT(a_ready_when_empty, clk, rst, !m_axis_tvalid |-> s_axis_tready)

  // no result survives reset
  `RWPC_ASSERT_ALWAYS(a_empty_after_reset, clk, $past(rst) |-> !m_axis_tvalid)

  `RWPC_ASSERT(a_cfg_ready, clk, rst, pready)

endmodule

bind relay_watchdog_power_cycler_core rwpc_checker u_rwpc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .pready        (pready)
);
`default_nettype wire

>>> bench/tb.sv
// Testbench for the relay watchdog power cycler: random events checked against a predictor.
`timescale 1ns / 1ps
module tb;
  import rwpc_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef logic [COUNT_BITS-1:0] count_t;

  // high bit first, relay_on in bit 0, as on m_axis_tdata
  typedef struct packed {
    logic ack_valid;
    logic save_mode;
    logic reboot_pulse;
    logic mode_now;
    logic led_on;
    logic relay_on;
  } levels_t;

  class relay_tracker;
    logic [RELOAD_W-1:0] reload;
    logic [LONG_W-1:0]   long_thr;
    logic                saved;
    logic                mode;
    count_t              countdown;
    logic                relay;
    logic                led;
    logic [HOLD_W-1:0]   hold_count;
    logic                holding;
    levels_t             levels_due[$];
    int                  errors;

    function void reset_state();
      reload     = RELOAD_RESET;
      long_thr   = LONG_RESET;
      saved      = MODE_RESET;
      mode       = saved;
      countdown  = '0;
      relay      = mode;
      led        = !mode;
      hold_count = '0;
      holding    = 1'b0;
      levels_due.delete();
      errors     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_RELOAD: reload   = value[RELOAD_W-1:0];
        REG_LONG:   long_thr = value[LONG_W-1:0];
        REG_SAVED:  saved    = value[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    function void note_event(logic [1:0] req, logic [7:0] cmd, logic pressed);
      levels_t r;
      r = '0;
      case (req)
        REQ_TICK:
          if (!holding) begin
            if (mode) begin
              led = !relay;
            end else if (countdown != '0) begin
              countdown = countdown - 1'b1;
              led = !led;
            end else begin
              r.reboot_pulse = 1'b1;
              relay = 1'b0;
              countdown = count_t'(reload);
            end
          end
        REQ_SERIAL:
          if (cmd == CMD_KEEPALIVE) begin
            countdown = count_t'(reload);
            r.ack_valid = 1'b1;
          end
        REQ_BUTTON:
          if (pressed) begin
            if (!holding) begin
              holding = 1'b1;
              hold_count = '0;
            end else begin
              if (hold_count != HOLD_MAX) hold_count = hold_count + 1'b1;
              if (hold_count > long_thr) led = !led;
            end
          end else if (holding) begin
            if (hold_count > long_thr) begin
              mode = !mode;
              r.save_mode = 1'b1;
            end else begin
              relay = !relay;
            end
            holding = 1'b0;
            hold_count = '0;
          end
        default: ;
      endcase
      r.relay_on = relay;
      r.led_on   = led;
      r.mode_now = mode;
      levels_due.push_back(r);
    endfunction

    function void check_levels(logic [OUT_DATA_W-1:0] got);
      string names[OUT_DATA_W] = '{"relay_on", "led_on", "mode_now", "reboot_pulse",
                                   "save_mode", "ack_valid", "pad", "pad"};
      logic [OUT_DATA_W-1:0] want;
      if (levels_due.size() == 0) begin
        $display("%0t: result %h with nothing expected", $time, got);
        errors++;
        return;
      end
      want = OUT_DATA_W'(levels_due.pop_front());
      if (got !== want) begin
        errors++;
        for (int i = 0; i < OUT_DATA_W; i++)
          if (got[i] !== want[i])
            $display("%0t: %s expected %b actual %b", $time, names[i], want[i], got[i]);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // [7:0] command, [8] button_pressed
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;  // [1:0] req_type
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // [0] relay .. [5] ack_valid
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  relay_tracker sb = new();
  bit sender_calm = 1'b0;
  bit hold_off_req = 1'b0;

  relay_watchdog_power_cycler_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_levels(m_axis_tdata);
  end

  // result side: random stalls, one calm stretch, one long hold-off on request
  initial begin
    int rx_cycle;
    rx_cycle = 0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (rx_cycle >= 200 && rx_cycle < 600) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 35);
      end
      rx_cycle++;
      @(posedge clk);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_item(input logic [1:0] req, input logic [7:0] cmd, input logic pressed);
    int gap;
    if (!sender_calm && $urandom_range(0, 99) < 35) begin
      gap = $urandom_range(1, 2);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {7'd0, pressed, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_event(req, cmd, pressed);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int budget);
    int sent;
    int pick;
    int k;
    int thr;
    bit first_press;
    sent = 0;
    first_press = 1'b1;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_item(REQ_TICK, 8'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 42) begin
        send_item(REQ_SERIAL, CMD_KEEPALIVE, 1'($urandom));
        sent++;
      end else if (pick < 47) begin
        send_item(REQ_SERIAL, 8'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 55) begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        sent++;
      end else begin
        thr = int'(sb.long_thr);
        if (first_press || (thr < 16 && $urandom_range(0, 1) == 1))
          k = thr + 1 + $urandom_range(0, 2);
        else
          k = $urandom_range(0, (thr < 6) ? thr : 6);
        first_press = 1'b0;
        send_item(REQ_BUTTON, 8'($urandom), 1'b1);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 99) < 10)
            send_item(($urandom_range(0, 1) == 1) ? REQ_TICK : REQ_SERIAL,
                      8'($urandom_range(0, 2)), 1'($urandom));
          send_item(REQ_BUTTON, 8'($urandom), 1'b1);
        end
        send_item(REQ_BUTTON, 8'($urandom), 1'b0);
        sent += k + 2;
      end
    end
  endtask

  initial begin
    int reloads[7]  = '{3, 0, 65535, 1, 2, 5, 0};
    int longs[7]    = '{1, 0, 2, 4, 255, 3, 0};
    int budgets[7]  = '{40, 30, 40, 30, 30, 40, 30};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    sb.reset_state();
    @(posedge clk);

    // plain mode at reset values
    send_item(REQ_TICK, 8'h00, 1'b0);
    send_item(REQ_SERIAL, CMD_KEEPALIVE, 1'b0);
    send_item(REQ_SERIAL, 8'h00, 1'b1);
    send_item(REQ_SERIAL, 8'hFF, 1'b0);
    send_item(REQ_UNUSED, 8'hAA, 1'b1);
    send_item(REQ_BUTTON, 8'h00, 1'b0);
    send_item(REQ_BUTTON, 8'h00, 1'b1);
    send_item(REQ_BUTTON, 8'h00, 1'b1);
    send_item(REQ_TICK, 8'h00, 1'b0);
    send_item(REQ_SERIAL, CMD_KEEPALIVE, 1'b1);
    send_item(REQ_BUTTON, 8'hFF, 1'b0);
    send_item(REQ_TICK, 8'h55, 1'b1);
    send_item(REQ_BUTTON, 8'h00, 1'b1);
    send_item(REQ_BUTTON, 8'h00, 1'b0);
    drain();

    // long press into watchdog mode, then countdown ticks and keepalive
    write_reg(REG_RELOAD, 32'd2);
    write_reg(REG_LONG, 32'd0);
    write_reg(REG_SAVED, 32'd0);
    send_item(REQ_BUTTON, 8'h00, 1'b1);
    send_item(REQ_BUTTON, 8'h00, 1'b1);
    send_item(REQ_BUTTON, 8'h00, 1'b1);
    send_item(REQ_BUTTON, 8'h00, 1'b0);
    repeat (4) send_item(REQ_TICK, 8'h00, 1'b0);
    send_item(REQ_SERIAL, CMD_KEEPALIVE, 1'b1);
    send_item(REQ_BUTTON, 8'h55, 1'b1);
    send_item(REQ_BUTTON, 8'h55, 1'b0);
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p == 6) begin
        reloads[p] = $urandom_range(0, 8);
        longs[p] = $urandom_range(0, 5);
      end
      write_reg(REG_RELOAD, reloads[p]);
      write_reg(REG_LONG, longs[p]);
      write_reg(REG_SAVED, $urandom_range(0, 1));
      sender_calm = (p == 2);
      if (p == 2) hold_off_req = 1'b1;
      run_random(budgets[p]);
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rwpc_pkg.sv
hw/rtl/relay_watchdog_power_cycler_core.sv
hw/rtl/rwpc_checker.sv
bench/tb.sv
